FILE: rtl/ppsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppsa_pkg
// Shared widths, register indexes, reset values and interface types of the
// pps oscillator phase aligner.
// ----------------------------------------------------------------------------
package ppsa_pkg;

  localparam int CountW    = 26;
  localparam int SecW      = 32;
  localparam int ErrW      = 27;
  localparam int ReloadW   = 32;
  localparam int DivisorW  = 10;
  localparam int DivW      = 32;
  localparam int DivCntW   = $clog2(DivW);
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 26;
  localparam int InDataW   = 64;
  localparam int OutDataW  = 152;

  localparam logic [CfgIdxW-1:0] RegRefPeriod    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRefHalf      = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSclkTicks    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRateDivisor  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLockLimit    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegNominalReload = 3'd5;

  localparam logic [25:0] RstRefPeriod     = 26'd24000000;
  localparam logic [24:0] RstRefHalf       = 25'd12000000;
  localparam logic [25:0] RstSclkTicks     = 26'd24000000;
  localparam logic [9:0]  RstRateDivisor   = 10'd375;
  localparam logic [15:0] RstLockLimit     = 16'd50;
  localparam logic [23:0] RstNominalReload = 24'd4096000;

  typedef struct packed {
    logic [25:0] ref_period;
    logic [24:0] ref_half;
    logic [25:0] sclk_ticks;
    logic [9:0]  rate_divisor;
    logic [15:0] lock_limit;
    logic [23:0] nominal_reload;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic apply;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_div;
  } dp_status_t;

endpackage

FILE: rtl/ppsa_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppsa_cfg
// Configuration register bank, written through an index and data channel.
// ----------------------------------------------------------------------------
module ppsa_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ppsa_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [ppsa_pkg::CfgDataW-1:0]    cfg_data_i,
  output ppsa_pkg::cfg_t                   cfg_o
);
  import ppsa_pkg::*;

  cfg_t cfg_d, cfg_q;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        RegRefPeriod:     cfg_d.ref_period     = cfg_data_i[25:0];
        RegRefHalf:       cfg_d.ref_half       = cfg_data_i[24:0];
        RegSclkTicks:     cfg_d.sclk_ticks     = cfg_data_i[25:0];
        RegRateDivisor:   cfg_d.rate_divisor   = cfg_data_i[9:0];
        RegLockLimit:     cfg_d.lock_limit     = cfg_data_i[15:0];
        RegNominalReload: cfg_d.nominal_reload = cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ref_period     <= RstRefPeriod;
      cfg_q.ref_half       <= RstRefHalf;
      cfg_q.sclk_ticks     <= RstSclkTicks;
      cfg_q.rate_divisor   <= RstRateDivisor;
      cfg_q.lock_limit     <= RstLockLimit;
      cfg_q.nominal_reload <= RstNominalReload;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/ppsa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppsa_ctrl
// Sequencer: takes an item, runs the divider when a correction is due and
// commits the result into the output register.
// ----------------------------------------------------------------------------
module ppsa_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  ppsa_pkg::dp_status_t   status_i,
  output ppsa_pkg::ctrl_cmd_t    cmd_o
);
  import ppsa_pkg::*;

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StDecide = 2'd1;
  localparam logic [1:0] StDiv    = 2'd2;
  localparam logic [1:0] StApply  = 2'd3;

  logic [1:0]         state_d, state_q;
  logic [DivCntW-1:0] cnt_d, cnt_q;
  logic               out_valid_d, out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          state_d    = StDecide;
        end
      end
      StDecide: begin
        if (status_i.need_div) begin
          cmd_o.div_start = 1'b1;
          cnt_d           = '0;
          state_d         = StDiv;
        end else begin
          state_d = StApply;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivW - 1)) begin
          state_d = StApply;
        end
      end
      StApply: begin
        if (!out_valid_q || m_axis_tready) begin
          cmd_o.apply = 1'b1;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;

  a_div_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_step |-> state_q == StDiv)
    else $error("divider stepped outside its state");

  a_apply_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.apply |-> (!out_valid_q || m_axis_tready))
    else $error("result committed over an untaken result");

  a_load_then_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == StDecide)
    else $error("item taken without decision step");

endmodule

FILE: rtl/ppsa_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppsa_dp
// Datapath: item register, one-bit-per-cycle restoring divider for the
// reload correction, alignment sequence, error and lock tracking.
// ----------------------------------------------------------------------------
module ppsa_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ppsa_pkg::cfg_t                  cfg_i,
  input  ppsa_pkg::ctrl_cmd_t             cmd_i,
  output ppsa_pkg::dp_status_t            status_o,
  input  logic [ppsa_pkg::InDataW-1:0]    s_axis_tdata,
  input  logic                            s_axis_tuser,
  output logic [ppsa_pkg::OutDataW-1:0]   m_axis_tdata,
  output logic                            m_axis_tuser
);
  import ppsa_pkg::*;

  function automatic logic [ErrW-1:0] mag(input logic signed [ErrW-1:0] v);
    logic signed [ErrW-1:0] n;
    n = -v;
    return v[ErrW-1] ? n : v;
  endfunction

  // item register
  logic              act_q;
  logic [CountW-1:0] count_q;
  logic [SecW-1:0]   sec_val_q;

  // divider
  logic [DivisorW-1:0] rem_d, rem_q;
  logic [DivW-1:0]     quo_d, quo_q;
  logic                neg_d, neg_q;

  // block state
  logic [SecW-1:0]    seconds_d, seconds_q;
  logic [ErrW-1:0]    cur_err_d, cur_err_q;
  logic [CountW-1:0]  cur_cap_d, cur_cap_q;
  logic [ErrW-1:0]    phase_d, phase_q;
  logic [ReloadW-1:0] period_d, period_q;
  logic [2:0]         step_d, step_q;
  logic               armed_d, armed_q;
  logic               done_d, done_q;
  logic               lock_d, lock_q;
  logic               rv_d, rv_q;
  logic [ReloadW-1:0] rval_d, rval_q;

  logic signed [27:0]     win_limit;
  logic                   beyond;
  logic signed [ErrW-1:0] diff;
  logic [ErrW-1:0]        abs_diff;
  logic [DivisorW-1:0]    divisor;
  logic [DivisorW:0]      trial;
  logic                   trial_ge;
  logic signed [33:0]     q_s;
  logic signed [33:0]     corr_sum;
  logic [ReloadW-1:0]     corr;
  logic [2:0]             step_inc;
  logic signed [ErrW-1:0] err_new;
  logic signed [ErrW-1:0] phase_new;
  logic [ErrW-1:0]        lim_ext;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q     <= s_axis_tuser;
      count_q   <= s_axis_tdata[CountW-1:0];
      sec_val_q <= s_axis_tdata[CountW+SecW-1:CountW];
    end
  end

  // capture window
  assign win_limit = $signed({2'b00, cfg_i.ref_period})
                   - $signed({11'd0, cfg_i.lock_limit, 1'b0});
  assign beyond    = $signed({2'b00, count_q}) > win_limit;
  assign status_o.need_div = !act_q && armed_q && (step_q == 3'd0) && !beyond;

  // divider
  assign diff     = $signed({2'b00, cfg_i.ref_half}) - $signed({1'b0, count_q});
  assign abs_diff = mag(diff);
  assign divisor  = (cfg_i.rate_divisor == '0) ? DivisorW'(1) : cfg_i.rate_divisor;
  assign trial    = {rem_q, quo_q[DivW-1]};
  assign trial_ge = trial >= {1'b0, divisor};

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    neg_d = neg_q;
    if (cmd_i.div_start) begin
      rem_d = '0;
      quo_d = {abs_diff[CountW-1:0], 6'd0};
      neg_d = diff[ErrW-1];
    end else if (cmd_i.div_step) begin
      rem_d = trial_ge ? DivisorW'(trial - {1'b0, divisor}) : trial[DivisorW-1:0];
      quo_d = {quo_q[DivW-2:0], trial_ge};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
  end

  // correction with saturation
  assign q_s      = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
  assign corr_sum = q_s + $signed({10'd0, cfg_i.nominal_reload});
  always_comb begin
    if (corr_sum[33:31] == 3'b000 || corr_sum[33:31] == 3'b111) begin
      corr = corr_sum[31:0];
    end else if (corr_sum[33]) begin
      corr = {1'b1, {(ReloadW-1){1'b0}}};
    end else begin
      corr = {1'b0, {(ReloadW-1){1'b1}}};
    end
  end

  assign step_inc  = step_q + 3'd1;
  assign err_new   = $signed({1'b0, count_q}) - $signed({1'b0, cur_cap_q});
  assign phase_new = $signed({2'b00, cfg_i.sclk_ticks[CountW-1:1]})
                   - $signed({1'b0, count_q});
  assign lim_ext   = {11'd0, cfg_i.lock_limit};

  always_comb begin
    seconds_d = seconds_q;
    cur_err_d = cur_err_q;
    cur_cap_d = cur_cap_q;
    phase_d   = phase_q;
    period_d  = period_q;
    step_d    = step_q;
    armed_d   = armed_q;
    done_d    = done_q;
    lock_d    = lock_q;
    rv_d      = rv_q;
    rval_d    = rval_q;
    if (cmd_i.apply) begin
      rv_d   = 1'b0;
      rval_d = '0;
      if (act_q) begin
        armed_d   = 1'b1;
        done_d    = 1'b0;
        seconds_d = sec_val_q;
      end else begin
        if (armed_q && !(step_q == 3'd0 && beyond)) begin
          if (step_q == 3'd0) begin
            rv_d   = 1'b1;
            rval_d = corr;
          end
          step_d = step_inc;
          if (step_inc == 3'd2) begin
            rv_d   = 1'b1;
            rval_d = {8'd0, cfg_i.nominal_reload};
          end
          if (step_inc >= 3'd4) begin
            step_d  = '0;
            armed_d = 1'b0;
            done_d  = 1'b1;
          end
        end
        cur_cap_d = count_q;
        cur_err_d = err_new;
        period_d  = {6'd0, cfg_i.sclk_ticks} + {{(ReloadW-ErrW){err_new[ErrW-1]}}, err_new};
        phase_d   = phase_new;
        if (mag(err_new) < lim_ext && mag(cur_err_q) < lim_ext
            && mag(phase_new) < lim_ext) begin
          lock_d = 1'b1;
        end
        seconds_d = seconds_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seconds_q <= '0;
      cur_err_q <= '0;
      cur_cap_q <= '0;
      phase_q   <= '0;
      period_q  <= '0;
      step_q    <= '0;
      armed_q   <= 1'b0;
      done_q    <= 1'b0;
      lock_q    <= 1'b0;
      rv_q      <= 1'b0;
      rval_q    <= '0;
    end else begin
      seconds_q <= seconds_d;
      cur_err_q <= cur_err_d;
      cur_cap_q <= cur_cap_d;
      phase_q   <= phase_d;
      period_q  <= period_d;
      step_q    <= step_d;
      armed_q   <= armed_d;
      done_q    <= done_d;
      lock_q    <= lock_d;
      rv_q      <= rv_d;
      rval_q    <= rval_d;
    end
  end

  // state only moves on a commit, which waits for the output slot
  assign m_axis_tdata = {seconds_q, done_q, lock_q, phase_q, cur_err_q, period_q, rval_q};
  assign m_axis_tuser = rv_q;

  a_armed_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(armed_q && done_q))
    else $error("alignment armed and done together");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q < 3'd4)
    else $error("alignment step out of range");

  a_idle_step_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !armed_q |-> step_q == 3'd0)
    else $error("alignment step moved while not armed");

  a_no_reload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rv_q |-> rval_q == '0)
    else $error("reload value without reload flag");

endmodule

FILE: rtl/pps_oscillator_phase_aligner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_oscillator_phase_aligner
// Top level: compares a local oscillator with a one-second reference and
// drives timer reloads for phase alignment.
// ----------------------------------------------------------------------------
// An item is a shift request (tuser high) or a one-second tick with the
// captured reference count (tuser low); each item gives exactly one result.
// A shift request or an ordinary tick passes through the decide and apply
// states to the result register; the tick that issues the phase correction
// also runs the divider state between them, because the correction goes
// through a restoring divider that resolves one quotient bit per cycle.
// The apply state waits until the output slot is free. The input is taken
// again as soon as the result is committed, even while that result still
// waits to be read; no new item is taken before then. Configuration writes
// are always accepted and must only be made while the block is idle.
module pps_oscillator_phase_aligner (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // slave side
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // captured_count, seconds_value, zero pad
  input  logic [ppsa_pkg::InDataW-1:0]    s_axis_tdata,
  // action
  input  logic                            s_axis_tuser,
  // master side
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // reload_value, period_estimate, frequency_error, phase_error, locked,
  // shift_done, seconds_count
  output logic [ppsa_pkg::OutDataW-1:0]   m_axis_tdata,
  // reload_valid
  output logic                            m_axis_tuser,
  // configuration
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ppsa_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [ppsa_pkg::CfgDataW-1:0]   cfg_data_i
);
  import ppsa_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  ppsa_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ppsa_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  ppsa_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .status_o     (status),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pps oscillator phase aligner. Ticks and shift
// requests go in over the stream port. Each result is predicted by a model of
// the aligner kept inside the bench, and every field of it is checked. The run
// covers several register settings, with random sender gaps and receiver
// stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import ppsa_pkg::*;

  localparam logic        ActTick    = 1'b0;
  localparam logic        ActShift   = 1'b1;
  localparam int          CycleLimit = 1500000;
  localparam logic [25:0] CountMax   = 26'h3FFFFFF;
  localparam longint      CountMaxL  = 67108863;
  localparam int unsigned CountMaxU  = 67108863;
  localparam longint      SatHigh    = 2147483647;
  localparam longint      SatLow     = -SatHigh - 1;

  typedef struct packed {
    logic        reload_valid;
    logic [31:0] reload_value;
    logic [31:0] period_estimate;
    logic [26:0] frequency_error;
    logic [26:0] phase_error;
    logic        locked;
    logic        shift_done;
    logic [31:0] seconds_count;
  } pps_result_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  pps_oscillator_phase_aligner dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // aligner model state
  cfg_t               mdl_cfg;
  logic [31:0]        mdl_seconds;
  logic signed [26:0] mdl_cur_err, mdl_prev_err, mdl_phase;
  logic [25:0]        mdl_prev_cap, mdl_cur_cap;
  logic [31:0]        mdl_period;
  logic [2:0]         mdl_step;
  logic               mdl_armed, mdl_done, mdl_lock;

  pps_result_t pending_results[$];
  int          mismatch_count = 0;
  int          items_sent     = 0;
  int          shifts_sent    = 0;
  int          results_seen   = 0;
  int          reloads_seen   = 0;
  int          alignments     = 0;
  int          config_sets    = 0;
  int          burst_left     = 0;
  bit          quiet_sender   = 1'b0;

  task automatic model_reset();
    mdl_cfg = '{ref_period: RstRefPeriod, ref_half: RstRefHalf, sclk_ticks: RstSclkTicks,
                rate_divisor: RstRateDivisor, lock_limit: RstLockLimit,
                nominal_reload: RstNominalReload};
    mdl_seconds  = '0;
    mdl_cur_err  = '0;
    mdl_prev_err = '0;
    mdl_phase    = '0;
    mdl_prev_cap = '0;
    mdl_cur_cap  = '0;
    mdl_period   = '0;
    mdl_step     = '0;
    mdl_armed    = 1'b0;
    mdl_done     = 1'b0;
    mdl_lock     = 1'b0;
  endtask

  function automatic longint window_limit();
    longint rp, ll;
    rp = mdl_cfg.ref_period;
    ll = mdl_cfg.lock_limit;
    return rp - 2 * ll;
  endfunction

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic aligner_predict(input logic act, input logic [25:0] cnt,
                                 input logic [31:0] secval, output pps_result_t res);
    longint cnt_l, half_l, div_l, nom_l, reload, err_l, per_l, phase_l, ll_l;
    logic   emit;
    logic   hold;
    emit   = 1'b0;
    hold   = 1'b0;
    reload = 0;
    cnt_l  = cnt;
    nom_l  = mdl_cfg.nominal_reload;
    ll_l   = mdl_cfg.lock_limit;
    if (act == ActShift) begin
      mdl_armed   = 1'b1;
      mdl_done    = 1'b0;
      mdl_seconds = secval;
    end else begin
      if (mdl_armed) begin
        if (mdl_step == 3'd0) begin
          if (cnt_l > window_limit()) begin
            hold = 1'b1;
          end else begin
            emit   = 1'b1;
            half_l = mdl_cfg.ref_half;
            if (mdl_cfg.rate_divisor == '0) div_l = 1;
            else div_l = mdl_cfg.rate_divisor;
            reload = (half_l - cnt_l) * 64 / div_l + nom_l;
            if (reload > SatHigh) reload = SatHigh;
            if (reload < SatLow) reload = SatLow;
          end
        end
        if (!hold) begin
          mdl_step = mdl_step + 3'd1;
          if (mdl_step == 3'd2) begin
            emit   = 1'b1;
            reload = nom_l;
          end
          if (mdl_step >= 3'd4) begin
            mdl_step  = '0;
            mdl_armed = 1'b0;
            mdl_done  = 1'b1;
            alignments++;
          end
        end
      end
      mdl_prev_cap = mdl_cur_cap;
      mdl_cur_cap  = cnt;
      mdl_prev_err = mdl_cur_err;
      err_l        = cnt_l - longint'(mdl_prev_cap);
      mdl_cur_err  = err_l[26:0];
      per_l        = longint'(mdl_cfg.sclk_ticks) + err_l;
      mdl_period   = per_l[31:0];
      phase_l      = longint'(mdl_cfg.sclk_ticks >> 1) - cnt_l;
      mdl_phase    = phase_l[26:0];
      if (!mdl_lock && magnitude(err_l) < ll_l && magnitude(mdl_prev_err) < ll_l &&
          magnitude(phase_l) < ll_l)
        mdl_lock = 1'b1;
      mdl_seconds = mdl_seconds + 32'd1;
    end
    res.reload_valid    = emit;
    res.reload_value    = emit ? reload[31:0] : '0;
    res.period_estimate = mdl_period;
    res.frequency_error = mdl_cur_err;
    res.phase_error     = mdl_phase;
    res.locked          = mdl_lock;
    res.shift_done      = mdl_done;
    res.seconds_count   = mdl_seconds;
  endtask

  // stimulus helpers

  function automatic logic [25:0] clamp_count(input longint v);
    if (v < 0) return '0;
    if (v > CountMaxL) return CountMax;
    return v[25:0];
  endfunction

  function automatic logic [25:0] window_count(input bit want_in);
    longint lim;
    lim = window_limit();
    if (want_in && lim >= 0) begin
      if (lim >= CountMaxL) return 26'($urandom_range(0, CountMaxU));
      return 26'($urandom_range(0, 32'(lim)));
    end
    if (!want_in && lim < CountMaxL) begin
      if (lim < 0) return 26'($urandom_range(0, CountMaxU));
      return 26'($urandom_range(32'(lim + 1), CountMaxU));
    end
    return 26'($urandom_range(0, CountMaxU));
  endfunction

  function automatic logic [25:0] random_count();
    int     off;
    longint lim;
    off = $urandom_range(0, 4000);
    off = off - 2000;
    lim = window_limit();
    case ($urandom_range(0, 5))
      0: return clamp_count(lim + off / 500);
      1: return clamp_count(longint'(mdl_cfg.sclk_ticks >> 1) + off);
      2: return clamp_count(longint'(mdl_cur_cap) + off);
      3: return ($urandom_range(0, 1) == 1) ? CountMax : '0;
      4: return window_count(1'b1);
      default: return 26'($urandom_range(0, CountMaxU));
    endcase
  endfunction

  function automatic logic [31:0] random_seconds();
    case ($urandom_range(0, 7))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'hFFFFFFFF;
      3: return 32'h00000000;
      default: return $urandom;
    endcase
  endfunction

  // sender: bursts of items with random gaps between them
  task automatic send_item(input logic act, input logic [25:0] cnt, input logic [31:0] secval);
    pps_result_t exp_r;
    int          gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 45) : $urandom_range(1, 5);
      if (quiet_sender) gap = 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, secval, cnt};
    s_axis_tuser  <= act;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    aligner_predict(act, cnt, secval, exp_r);
    pending_results.push_back(exp_r);
    items_sent++;
    if (act == ActShift) shifts_sent++;
  endtask

  // hold the sender until every result is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegRefPeriod:     mdl_cfg.ref_period     = val[25:0];
      RegRefHalf:       mdl_cfg.ref_half       = val[24:0];
      RegSclkTicks:     mdl_cfg.sclk_ticks     = val[25:0];
      RegRateDivisor:   mdl_cfg.rate_divisor   = val[9:0];
      RegLockLimit:     mdl_cfg.lock_limit     = val[15:0];
      RegNominalReload: mdl_cfg.nominal_reload = val[23:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic apply_config(input int unsigned rp, input int unsigned rh,
                              input int unsigned st, input int unsigned rd,
                              input int unsigned ll, input int unsigned nr);
    write_reg(RegRefPeriod, rp[25:0]);
    write_reg(RegRefHalf, rh[25:0]);
    write_reg(RegSclkTicks, st[25:0]);
    write_reg(RegRateDivisor, rd[25:0]);
    write_reg(RegLockLimit, ll[25:0]);
    write_reg(RegNominalReload, nr[25:0]);
    config_sets++;
  endtask

  task automatic send_sequence();
    int kind, n;
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      send_item(ActShift, random_count(), random_seconds());
      n = $urandom_range(0, 2);
      repeat (n) send_item(ActTick, window_count(1'b0), $urandom);
      send_item(ActTick, window_count(1'b1), $urandom);
      n = $urandom_range(3, 5);
      repeat (n) send_item(ActTick, random_count(), $urandom);
    end else if (kind <= 7) begin
      send_item(ActTick, random_count(), $urandom);
    end else if (kind == 8) begin
      send_item(ActShift, random_count(), random_seconds());
    end else begin
      // shift request landing in the middle of a running sequence
      send_item(ActShift, random_count(), random_seconds());
      n = $urandom_range(1, 3);
      repeat (n) send_item(ActTick, random_count(), $urandom);
      send_item(ActShift, random_count(), random_seconds());
    end
  endtask

  task automatic run_random(input int total);
    int start;
    start = items_sent;
    while (items_sent - start < total) begin
      send_sequence();
      if ($urandom_range(0, 59) == 0) drain();
    end
    drain();
  endtask

  // tests

  task automatic test_directed();
    send_item(ActTick, '0, '0);
    send_item(ActTick, CountMax, 32'hFFFFFFFF);
    send_item(ActShift, CountMax, 32'h7FFFFFFF);
    send_item(ActTick, 26'd24000000, $urandom);
    send_item(ActShift, '0, 32'h80000000);
    send_item(ActTick, 26'd23999901, $urandom);
    send_item(ActTick, 26'd23999900, $urandom);
    send_item(ActTick, 26'd12000000, $urandom);
    send_item(ActTick, 26'd11999990, $urandom);
    send_item(ActTick, 26'd12000005, $urandom);
    send_item(ActTick, '0, $urandom);
    send_item(ActShift, 26'($urandom), 32'hFFFFFFFF);
    send_item(ActTick, '0, $urandom);
    send_item(ActShift, 26'($urandom), 32'h00000000);
    send_item(ActTick, 26'd12000000, $urandom);
    send_item(ActTick, CountMax, $urandom);
    send_item(ActTick, '0, $urandom);
    send_item(ActShift, CountMax, 32'h7FFFFFFF);
    send_item(ActTick, 26'h2AAAAAA, 32'h55555555);
    send_item(ActTick, 26'h1555555, 32'hAAAAAAAA);
    drain();
  endtask

  task automatic test_register_extremes();
    apply_config(1000000, 500000, 1000000, 1, 1, 1);
    run_random(200);
    apply_config(67108863, 33554431, 67108863, 1023, 65535, 16777215);
    run_random(200);
  endtask

  task automatic test_saturation();
    apply_config(67108863, 33554431, 24000000, 1, 1, 16777215);
    send_item(ActShift, 26'($urandom), $urandom);
    send_item(ActTick, '0, $urandom);
    run_random(100);
    apply_config(67108863, 500000, 24000000, 1, 1, 1);
    send_item(ActShift, 26'($urandom), $urandom);
    send_item(ActTick, 26'd67108861, $urandom);
    run_random(100);
  endtask

  task automatic test_zero_divisor();
    apply_config(24000000, 12000000, 24000000, 0, 50, 4096000);
    run_random(150);
  endtask

  task automatic test_closed_window();
    // capture window below zero, armed ticks never advance
    apply_config(100000, 50000, 24000000, 375, 65535, 4096000);
    send_item(ActShift, 26'($urandom), random_seconds());
    send_item(ActTick, '0, $urandom);
    send_item(ActTick, 26'd50000, $urandom);
    run_random(100);
  endtask

  task automatic test_lock();
    int off;
    apply_config(24000000, 12000000, 24000001, 375, 500, 4096000);
    send_item(ActShift, 26'($urandom), random_seconds());
    repeat (40) begin
      off = $urandom_range(0, 200);
      send_item(ActTick, clamp_count(12000000 + off - 100), $urandom);
    end
    drain();
  endtask

  task automatic test_random_settings();
    quiet_sender = 1'b1;
    apply_config(RstRefPeriod, RstRefHalf, RstSclkTicks, RstRateDivisor, RstLockLimit,
                 RstNominalReload);
    run_random(200);
    quiet_sender = 1'b0;
    repeat (3) begin
      apply_config($urandom_range(1000000, 67108863), $urandom_range(500000, 33554431),
                   $urandom_range(1000000, 67108863), $urandom_range(1, 1023),
                   $urandom_range(1, 65535), $urandom_range(1, 16777215));
      run_random(200);
    end
  endtask

  // receiver stalls, the stall percentage is redrawn from 0, 25, 60 and 90
  int rx_cycle  = 0;
  int stall_pct = 0;
  always @(posedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 160 == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 25;
        2: stall_pct = 60;
        default: stall_pct = 90;
      endcase
    end
    m_axis_tready <= ($urandom_range(1, 100) > stall_pct);
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    pps_result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no item pending");
        mismatch_count++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("reload_valid", exp_r.reload_valid, m_axis_tuser);
        check_field("reload_value", exp_r.reload_value, m_axis_tdata[31:0]);
        check_field("period_estimate", exp_r.period_estimate, m_axis_tdata[63:32]);
        check_field("frequency_error", exp_r.frequency_error, m_axis_tdata[90:64]);
        check_field("phase_error", exp_r.phase_error, m_axis_tdata[117:91]);
        check_field("locked", exp_r.locked, m_axis_tdata[118]);
        check_field("shift_done", exp_r.shift_done, m_axis_tdata[119]);
        check_field("seconds_count", exp_r.seconds_count, m_axis_tdata[151:120]);
        results_seen++;
        if (exp_r.reload_valid) reloads_seen++;
      end
    end
  end

  int cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("** pps_oscillator_phase_aligner: FAILED **");
      $finish;
    end
  end

  initial begin
    model_reset();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (5) @(posedge clk_i);
    test_directed();
    test_register_extremes();
    test_saturation();
    test_zero_divisor();
    test_closed_window();
    test_random_settings();
    test_lock();
    drain();
    repeat (40) @(posedge clk_i);
    $display("covered %0d items (%0d shift requests), %0d results, %0d reloads, %0d alignments",
             items_sent, shifts_sent, results_seen, reloads_seen, alignments);
    $display("over %0d register settings, lock flag %s", config_sets,
             mdl_lock ? "reached" : "not reached");
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("** pps_oscillator_phase_aligner: PASSED **");
    end else begin
      $display("** pps_oscillator_phase_aligner: FAILED **");
    end
    $finish;
  end

endmodule
